>>> rtl/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants
// Item structs, register indexes, divider widths and reset values used by the
// step/direction pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

	localparam int AXES_DEF   = 3;

	// configuration register widths and indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int INV_W      = 3;
	localparam int ACCEL_W    = 24;
	localparam int MINIV_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVAL   = 2'd2;

	localparam logic [INV_W-1:0]   INV_RESET   = 3'd0;
	localparam logic [ACCEL_W-1:0] ACCEL_RESET = 24'd1000000;
	localparam logic [MINIV_W-1:0] MINIV_RESET = 16'd100;

	localparam logic [15:0] IDLE_RELOAD = 16'd999;

	// serial divider: dividend is at most q*9 < 2^28, divisor is a 33-bit distance
	localparam int DVD_W = 28;
	localparam int DVS_W = 33;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam logic [DVS_W-1:0] DIV_BY_FIVE = 33'd5;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] target;
	} spg_in_t;

	typedef struct packed {
		logic [1:0]         axis_out;
		logic [15:0]        reload;
		logic               step_level;
		logic               dir_level;
		logic signed [31:0] position;
	} spg_out_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic        upd;
		logic [31:0] target;
		logic        inv;
	} axis_req_t;

	typedef struct packed {
		logic             at_target;
		logic [DVS_W-1:0] span;
		logic             step_level;
		logic             dir_level;
		logic [31:0]      position;
	} axis_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_Q,
		ST_DIV_R,
		ST_OUT
	} fsm_state_t;

endpackage

`default_nettype wire

>>> rtl/spg_div.sv
// ----------------------------------------------------------------------------
// spg_div: restoring serial divider
// One quotient bit per cycle; the dividend shifts out of the top of the
// quotient register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spg_pkg::div_req_t req,
	output spg_pkg::div_rsp_t      rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [spg_pkg::CNT_W-1:0]   cnt_q;
	logic [spg_pkg::DVS_W-1:0]   rem_q;
	logic [spg_pkg::DVD_W-1:0]   quo_q;
	logic [spg_pkg::DVS_W-1:0]   dvs_q;
	logic [spg_pkg::DVS_W:0]     trial;
	logic [spg_pkg::DVS_W:0]     diff;
	logic                        fits;

	assign trial = {rem_q, quo_q[spg_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= spg_pkg::CNT_W'(spg_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == spg_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low DVS_W bits suffice
			rem_q <= fits ? diff[spg_pkg::DVS_W-1:0] : trial[spg_pkg::DVS_W-1:0];
			quo_q <= {quo_q[spg_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/spg_axis.sv
// ----------------------------------------------------------------------------
// spg_axis: per-axis position and pulse sequencer state
// Holds position, direction and pin state of each axis, works out the
// distance to the target and advances the step pulse on an update.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_axis #(
	parameter int AXES = spg_pkg::AXES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         axis,
	input  wire spg_pkg::axis_req_t req,
	output spg_pkg::axis_rsp_t      rsp
);

	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	logic [31:0] pos_q   [AXES];
	logic        mdir_q  [AXES];
	logic        phase_q [AXES];
	logic        step_q  [AXES];
	logic        dirp_q  [AXES];

	logic [AW-1:0] idx;
	logic [31:0]   pos;
	logic          at_tgt;
	logic          below;
	logic          want;
	logic [32:0]   d_up;
	logic [32:0]   d_dn;
	logic [31:0]   pos_n;
	logic          mdir_n;
	logic          phase_n;
	logic          step_n;
	logic          dirp_n;

	assign idx    = AW'(axis);
	assign pos    = pos_q[idx];
	assign at_tgt = (pos == req.target);
	assign below  = $signed(pos) < $signed(req.target);
	assign want   = ~below;
	assign d_up   = {req.target[31], req.target} - {pos[31], pos};
	assign d_dn   = {pos[31], pos} - {req.target[31], req.target};

	always_comb begin
		pos_n   = pos;
		mdir_n  = mdir_q[idx];
		phase_n = phase_q[idx];
		step_n  = step_q[idx];
		dirp_n  = dirp_q[idx];
		if (!at_tgt) begin
			if (!phase_q[idx]) begin
				dirp_n = want ^ req.inv;
				// a reversal costs one item with no pulse
				if (mdir_q[idx] != want) begin
					mdir_n = want;
				end else begin
					step_n  = 1'b0;
					phase_n = 1'b1;
				end
			end else begin
				step_n  = 1'b1;
				phase_n = 1'b0;
				pos_n   = mdir_q[idx] ? pos - 32'd1 : pos + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i]   <= '0;
				mdir_q[i]  <= 1'b0;
				phase_q[i] <= 1'b0;
				step_q[i]  <= 1'b1;
				dirp_q[i]  <= 1'b0;
			end
		end else if (req.upd) begin
			pos_q[idx]   <= pos_n;
			mdir_q[idx]  <= mdir_n;
			phase_q[idx] <= phase_n;
			step_q[idx]  <= step_n;
			dirp_q[idx]  <= dirp_n;
		end
	end

	assign rsp.at_target  = at_tgt;
	assign rsp.span       = below ? d_up : d_dn;
	assign rsp.step_level = step_n;
	assign rsp.dir_level  = dirp_n;
	assign rsp.position   = pos_n;

endmodule

`default_nettype wire

>>> rtl/stepper_position_pulse_generator_top.sv
// ----------------------------------------------------------------------------
// stepper_position_pulse_generator_top: step/direction pulse generator
// Per timer tick of one axis: moves the step pulse sequencer and works out the
// next timer reload from the distance to the target.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake              payload
//  in_*         input      in_valid / in_stall    in_item  (spg_in_t)
//  out_*        output     out_valid / out_stall  out_item (spg_out_t)
//  cfg_*        input      cfg_we                 cfg_index, cfg_data
//
//  An item that moves the axis goes through an evaluation state, two passes of
//  the serial divider (accel / distance, then q * 9 / 5), each ending when the
//  divider raises done, and an output state that loads the result once the
//  output register is free; only then is the next item taken. An item already
//  at its target goes from evaluation straight to the output state; one for an
//  axis beyond AXES returns to idle and gives no result. Items are taken one at
//  a time; in_stall is low only when idle. A result waits in the output register
//  under out_stall while the next item is accepted. Reset needs no sweep.
//
`default_nettype none

module stepper_position_pulse_generator_top #(
	parameter int AXES = spg_pkg::AXES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire spg_pkg::spg_in_t                  in_item,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output spg_pkg::spg_out_t                      out_item,
	input  wire logic                              cfg_we,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [spg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	spg_pkg::fsm_state_t state_q, state_n;

	logic [spg_pkg::INV_W-1:0]   inv_q;
	logic [spg_pkg::ACCEL_W-1:0] accel_q;
	logic [spg_pkg::MINIV_W-1:0] minv_q;

	logic [1:0]  axis_q;
	logic [31:0] target_q;
	logic [15:0] reload_q;
	logic        step_q;
	logic        dir_q;
	logic [31:0] pos_q;
	logic        out_valid_q;
	spg_pkg::spg_out_t out_q;

	spg_pkg::axis_req_t areq;
	spg_pkg::axis_rsp_t arsp;
	spg_pkg::div_req_t  dreq;
	spg_pkg::div_rsp_t  drsp;

	logic                      axis_bad;
	logic                      out_free;
	logic                      load_out;
	logic [spg_pkg::DVD_W-1:0] q9;
	logic [15:0]               clamped;

	assign axis_bad = {30'd0, axis_q} >= 32'(AXES);
	assign out_free = !out_valid_q || !out_stall;
	assign q9       = {1'b0, drsp.quotient[23:0], 3'd0} + {4'd0, drsp.quotient[23:0]};

	// raise to the minimum interval, then saturate to 16 bits
	always_comb begin
		if (drsp.quotient < {12'd0, minv_q})
			clamped = minv_q;
		else if (|drsp.quotient[spg_pkg::DVD_W-1:16])
			clamped = 16'hFFFF;
		else
			clamped = drsp.quotient[15:0];
	end

	spg_axis #(
		.AXES(AXES)
	) u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.axis   (axis_q),
		.req    (areq),
		.rsp    (arsp)
	);

	spg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= spg_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n       = state_q;
		in_stall      = 1'b1;
		load_out      = 1'b0;
		areq.upd      = 1'b0;
		areq.target   = target_q;
		areq.inv      = (axis_q < 2'd3) ? inv_q[axis_q] : 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = {4'd0, accel_q};
		dreq.divisor  = arsp.span;
		unique case (state_q)
			spg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_n = spg_pkg::ST_EVAL;
			end
			spg_pkg::ST_EVAL: begin
				if (axis_bad) begin
					state_n = spg_pkg::ST_IDLE;
				end else begin
					areq.upd = 1'b1;
					if (arsp.at_target) begin
						state_n = spg_pkg::ST_OUT;
					end else begin
						dreq.start = 1'b1;
						state_n    = spg_pkg::ST_DIV_Q;
					end
				end
			end
			spg_pkg::ST_DIV_Q: begin
				dreq.dividend = q9;
				dreq.divisor  = spg_pkg::DIV_BY_FIVE;
				if (drsp.done) begin
					dreq.start = 1'b1;
					state_n    = spg_pkg::ST_DIV_R;
				end
			end
			spg_pkg::ST_DIV_R: begin
				if (drsp.done)
					state_n = spg_pkg::ST_OUT;
			end
			spg_pkg::ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_n  = spg_pkg::ST_IDLE;
				end
			end
			default: state_n = spg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q   <= spg_pkg::INV_RESET;
			accel_q <= spg_pkg::ACCEL_RESET;
			minv_q  <= spg_pkg::MINIV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spg_pkg::CFG_DIR_INVERT: inv_q   <= cfg_data[spg_pkg::INV_W-1:0];
				spg_pkg::CFG_ACCEL:      accel_q <= cfg_data[spg_pkg::ACCEL_W-1:0];
				spg_pkg::CFG_MIN_IVAL:   minv_q  <= cfg_data[spg_pkg::MINIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spg_pkg::ST_IDLE && in_valid) begin
			axis_q   <= in_item.axis;
			target_q <= in_item.target;
		end
		if (state_q == spg_pkg::ST_EVAL) begin
			step_q   <= arsp.step_level;
			dir_q    <= arsp.dir_level;
			pos_q    <= arsp.position;
			reload_q <= spg_pkg::IDLE_RELOAD;
		end
		if (state_q == spg_pkg::ST_DIV_R && drsp.done)
			reload_q <= clamped;
		if (load_out) begin
			out_q.axis_out   <= axis_q;
			out_q.reload     <= reload_q;
			out_q.step_level <= step_q;
			out_q.dir_level  <= dir_q;
			out_q.position   <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: step/direction pulse generator
// Drives timer ticks for each axis through the valid/stall input channel.
// Every result is checked against a local prediction of the pulse sequencer
// and the reload arithmetic. Runs directed ticks, register extremes and long
// random move sequences, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	localparam int AXES     = spg_pkg::AXES_DEF;
	localparam int WD_LIMIT = 4000;
	localparam int SETTLE   = 80;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	spg_pkg::spg_in_t               in_item;
	logic                           out_valid;
	logic                           out_stall;
	spg_pkg::spg_out_t              out_item;
	logic                           cfg_we;
	logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [spg_pkg::CFG_DATA_W-1:0] cfg_data;

	// local copy of the registers and per-axis state
	logic [spg_pkg::INV_W-1:0]   cfg_inv;
	logic [spg_pkg::ACCEL_W-1:0] cfg_accel;
	logic [spg_pkg::MINIV_W-1:0] cfg_min;
	logic [31:0]        axis_pos [AXES];
	bit                 axis_dir [AXES];
	bit                 pulse_due [AXES];
	bit                 step_lvl [AXES];
	bit                 dir_lvl [AXES];

	spg_pkg::spg_out_t tick_reports_due [$];

	bit no_idle = 1'b0;
	int error_count = 0;
	int ticks_sent = 0;
	int ignored_sent = 0;
	int reports_checked = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;

	stepper_position_pulse_generator_top #(
		.AXES(AXES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the report of one tick and advances the local axis state.
	// Returns 0 for an axis that does not exist.
	function automatic bit axis_tick_outcome(input spg_pkg::spg_in_t it,
			output spg_pkg::spg_out_t rep);
		int unsigned       a;
		logic [31:0]       pos;
		logic [31:0]       tgt;
		longint            sp;
		longint            st;
		longint unsigned   span;
		longint unsigned   ival;
		bit                want;
		logic [15:0]       rl;
		rep = '0;
		a = it.axis;
		if (a >= AXES)
			return 1'b0;
		pos = axis_pos[a];
		tgt = it.target;
		if (pos == tgt) begin
			rl = spg_pkg::IDLE_RELOAD;
		end else begin
			sp = longint'($signed(pos));
			st = longint'($signed(tgt));
			want = !(sp < st);
			span = (sp < st) ? longint'(st - sp) : longint'(sp - st);
			ival = (64'(cfg_accel) / span) * 9 / 5;
			if (ival < 64'(cfg_min))
				ival = 64'(cfg_min);
			if (ival > 64'd65535)
				ival = 64'd65535;
			rl = ival[15:0];
			if (!pulse_due[a]) begin
				dir_lvl[a] = want ^ cfg_inv[a];
				if (axis_dir[a] != want) begin
					// direction change: this tick gives no pulse
					axis_dir[a] = want;
				end else begin
					step_lvl[a] = 1'b0;
					pulse_due[a] = 1'b1;
				end
			end else begin
				// rising edge completes the pulse in the stored direction
				step_lvl[a] = 1'b1;
				pulse_due[a] = 1'b0;
				axis_pos[a] = axis_dir[a] ? pos - 32'd1 : pos + 32'd1;
			end
		end
		rep.axis_out   = a[1:0];
		rep.reload     = rl;
		rep.step_level = step_lvl[a];
		rep.dir_level  = dir_lvl[a];
		rep.position   = axis_pos[a];
		return 1'b1;
	endfunction

	task automatic field_check(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", fname, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		spg_pkg::spg_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_reports_due.size() == 0) begin
				$error("result with nothing outstanding: axis %0d", out_item.axis_out);
				error_count++;
			end else begin
				want = tick_reports_due.pop_front();
				field_check("axis_out", 32'(want.axis_out), 32'(out_item.axis_out));
				field_check("reload", 32'(want.reload), 32'(out_item.reload));
				field_check("step_level", 32'(want.step_level), 32'(out_item.step_level));
				field_check("dir_level", 32'(want.dir_level), 32'(out_item.dir_level));
				field_check("position", want.position, out_item.position);
				reports_checked++;
			end
		end
	end

	always @(posedge clk)
		out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 24);

	// watchdog: cycles in which neither channel moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("testbench: no progress for %0d cycles", WD_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Valid is left high after acceptance so that a following item is not
	// lowered and raised in the same step.
	task automatic send_tick(input logic [1:0] ax, input logic [31:0] tgt);
		spg_pkg::spg_in_t  it;
		spg_pkg::spg_out_t rep;
		it.axis = ax;
		it.target = tgt;
		if (!no_idle && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		if (axis_tick_outcome(it, rep)) begin
			tick_reports_due.push_back(rep);
			ticks_sent++;
		end else begin
			ignored_sent++;
		end
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (tick_reports_due.size() != 0)
			@(posedge clk);
		// an ignored item may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_register(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
			input logic [spg_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spg_pkg::CFG_DIR_INVERT: cfg_inv = val[spg_pkg::INV_W-1:0];
			spg_pkg::CFG_ACCEL:      cfg_accel = val[spg_pkg::ACCEL_W-1:0];
			spg_pkg::CFG_MIN_IVAL:   cfg_min = val[spg_pkg::MINIV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [spg_pkg::INV_W-1:0] inv,
			input logic [spg_pkg::ACCEL_W-1:0] acc,
			input logic [spg_pkg::MINIV_W-1:0] mn);
		wait_quiet();
		set_register(spg_pkg::CFG_DIR_INVERT, spg_pkg::CFG_DATA_W'(inv));
		set_register(spg_pkg::CFG_ACCEL, spg_pkg::CFG_DATA_W'(acc));
		set_register(spg_pkg::CFG_MIN_IVAL, spg_pkg::CFG_DATA_W'(mn));
		settings_applied++;
	endtask

	// short moves around the present positions
	task automatic near_moves(input int n);
		int unsigned a;
		int          off;
		for (int i = 0; i < n; i++) begin
			a = $urandom_range(0, AXES - 1);
			off = int'($urandom_range(0, 6)) - 3;
			send_tick(a[1:0], axis_pos[a] + 32'(off));
		end
	endtask

	task automatic test_directed_defaults();
		send_tick(2'd0, 32'd0);
		send_tick(2'd3, $urandom);
		send_tick(2'd0, 32'd1);
		send_tick(2'd0, 32'd1);
		send_tick(2'd0, 32'd1);
		// direction change, then a pulse starts towards the most negative target
		send_tick(2'd1, 32'h8000_0000);
		send_tick(2'd1, 32'h8000_0000);
		// target reached with a pulse pending: pulse stays pending
		send_tick(2'd1, 32'd0);
		// target moved the other way: pulse completes in the stored direction
		send_tick(2'd1, 32'd5);
		send_tick(2'd1, 32'd5);
		send_tick(2'd2, 32'h7FFF_FFFF);
		send_tick(2'd2, 32'h7FFF_FFFF);
		send_tick(2'd0, 32'hFFFF_FFFF);
		send_tick(2'd0, 32'hFFFF_FFFF);
		send_tick(2'd3, 32'hFFFF_FFFF);
		send_tick(2'd2, 32'h0000_0001);
		send_tick(2'd3, 32'h0000_0000);
	endtask

	task automatic test_register_extremes();
		apply_setting(3'd7, 24'hFF_FFFF, 16'hFFFF);
		near_moves(14);
		// no lower bound and zero dividend: reload drops to zero
		apply_setting(3'd0, 24'd0, 16'd0);
		near_moves(10);
		apply_setting(3'd5, 24'd1, 16'd1);
		near_moves(12);
		apply_setting(3'd2, 24'd5000, 16'd3);
		near_moves(12);
		apply_setting(spg_pkg::INV_RESET, spg_pkg::ACCEL_RESET, spg_pkg::MINIV_RESET);
		near_moves(8);
	endtask

	task automatic test_random_traffic();
		logic [31:0]     goal [AXES];
		int unsigned     a;
		int unsigned     roll;
		int              off;
		int              stop_at;
		logic [spg_pkg::ACCEL_W-1:0] acc;
		logic [spg_pkg::MINIV_W-1:0] mn;
		for (int i = 0; i < AXES; i++)
			goal[i] = axis_pos[i];
		for (int ph = 0; ph < 4; ph++) begin
			case ($urandom_range(0, 3))
				0: acc = spg_pkg::ACCEL_W'($urandom);
				1: acc = spg_pkg::ACCEL_W'($urandom_range(1, 5000));
				2: acc = 24'hFF_FFFF;
				default: acc = spg_pkg::ACCEL_RESET;
			endcase
			case ($urandom_range(0, 3))
				0: mn = spg_pkg::MINIV_W'($urandom_range(0, 3));
				1: mn = spg_pkg::MINIV_W'($urandom_range(1, 2000));
				2: mn = 16'hFFFF;
				default: mn = spg_pkg::MINIV_RESET;
			endcase
			apply_setting(spg_pkg::INV_W'($urandom_range(0, 7)), acc, mn);
			// third phase runs flat out on both channels
			no_idle = (ph == 2);
			stop_at = ticks_sent + 220;
			while (ticks_sent < stop_at) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					send_tick(2'd3, $urandom);
				end else if (roll < 25) begin
					a = $urandom_range(0, AXES - 1);
					send_tick(a[1:0], $urandom);
				end else begin
					a = $urandom_range(0, AXES - 1);
					roll = $urandom_range(0, 99);
					if (roll < 12) begin
						off = int'($urandom_range(0, 12)) - 6;
						goal[a] = axis_pos[a] + 32'(off);
					end else if (roll < 15) begin
						goal[a] = $urandom;
					end
					send_tick(a[1:0], goal[a]);
				end
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_inv = spg_pkg::INV_RESET;
		cfg_accel = spg_pkg::ACCEL_RESET;
		cfg_min = spg_pkg::MINIV_RESET;
		for (int i = 0; i < AXES; i++) begin
			axis_pos[i] = '0;
			axis_dir[i] = 1'b0;
			pulse_due[i] = 1'b0;
			step_lvl[i] = 1'b1;
			dir_lvl[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_random_traffic();
		wait_quiet();

		if (tick_reports_due.size() != 0) begin
			$error("%0d results never arrived", tick_reports_due.size());
			error_count++;
		end
		$display("testbench: %0d ticks checked (%0d sent), %0d items for absent axes ignored",
			reports_checked, ticks_sent, ignored_sent);
		$display("testbench: %0d register settings applied, %0d mismatches",
			settings_applied, error_count);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
